// ----- design/tvs_pkg.sv -----
// Shared types, constants and fixed-point multiply helpers for the vesselness score.
// Used by tvs_exp, tubular_vesselness_score and its testbench; depends on nothing else.
package tvs_pkg;

    localparam int QF                  = 56;
    localparam int EIGEN_WIDTH_DEF     = 32;
    localparam int SCORE_FRAC_BITS_DEF = 16;
    localparam int EXP_LAT             = 103;

    localparam logic [15:0] MAX_INT_RESET = 16'd255;

    typedef logic [63:0] t_q64;

    localparam t_q64 Q_ONE     = t_q64'(1) << QF;
    localparam t_q64 EXP_LIMIT = t_q64'(128) << QF;

    // four 32x32 partial products of a 64x64 multiply
    typedef struct packed {
        logic [63:0] ll;
        logic [63:0] lh;
        logic [63:0] hl;
        logic [63:0] hh;
    } t_pp;

    // per-item control that travels beside the data
    typedef struct packed {
        logic valid;
        logic kill;
        logic big;
    } t_ctl;

    function automatic t_pp mul_parts(input t_q64 a, input t_q64 b);
        t_pp p;
        p.ll = 64'(a[31:0])  * 64'(b[31:0]);
        p.lh = 64'(a[31:0])  * 64'(b[63:32]);
        p.hl = 64'(a[63:32]) * 64'(b[31:0]);
        p.hh = 64'(a[63:32]) * 64'(b[63:32]);
        return p;
    endfunction

    function automatic logic [127:0] mul_full(input t_pp p);
        return {64'd0, p.ll} + {32'd0, p.lh, 32'd0} + {32'd0, p.hl, 32'd0} + {p.hh, 64'd0};
    endfunction

    // (a*b) >> QF, rounded half up
    function automatic t_q64 mul_round(input t_pp p);
        logic [127:0] s;
        s = mul_full(p) + (128'd1 << (QF - 1));
        return s[QF+63:QF];
    endfunction

    // (a*b) >> 64
    function automatic t_q64 mul_high(input t_pp p);
        logic [127:0] s;
        s = mul_full(p);
        return s[127:64];
    endfunction

endpackage

// ----- design/tvs_exp.sv -----
// Pipelined exp(-t) on unsigned Q.56 values: Taylor series on t/1024, then ten squarings.
// Depends on tvs_pkg; advances when i_en is high.
module tvs_exp
    import tvs_pkg::*;
(
    input  logic i_clk,
    input  logic i_en,
    input  t_q64 i_t,
    output t_q64 o_e
);

    localparam int N_TERMS = 16;
    localparam int N_SQ    = 10;
    localparam int N_SUB   = 5;

    typedef logic [63-10:0] t_y;

    t_y   r_y;
    logic r_zero [EXP_LAT-1];

    t_pp  r_b_pp   [N_TERMS];
    t_q64 r_b_prod [N_TERMS][3];
    t_pp  r_b_rp   [N_TERMS];
    t_q64 r_b_qe   [N_TERMS];
    t_q64 r_b_term [N_TERMS];
    t_q64 r_b_sum  [N_TERMS][N_SUB];
    t_y   r_b_y    [N_TERMS][N_SUB];

    t_q64 r_sum;
    t_pp  r_sq_pp [N_SQ];
    t_q64 r_sq    [N_SQ];
    t_q64 r_e;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_y       <= i_t[63:10];
            r_zero[0] <= (i_t >= EXP_LIMIT);
            for (int i = 1; i < EXP_LAT - 1; i++) begin
                r_zero[i] <= r_zero[i-1];
            end
        end
    end

    for (genvar k = 0; k < N_TERMS; k++) begin : g_term
        localparam int unsigned DIVN  = k + 1;
        localparam t_q64        RECIP = 64'hFFFF_FFFF_FFFF_FFFF / DIVN;
        localparam bit          ADD   = ((k % 2) == 0);

        t_q64 w_term_in;
        t_q64 w_sum_in;
        t_y   w_y_in;
        t_q64 w_rem;

        if (k == 0) begin : g_first
            assign w_term_in = Q_ONE;
            assign w_sum_in  = '0;
            assign w_y_in    = r_y;
        end else begin : g_next
            assign w_term_in = r_b_term[k-1];
            assign w_sum_in  = r_b_sum[k-1][N_SUB-1];
            assign w_y_in    = r_b_y[k-1][N_SUB-1];
        end

        assign w_rem = r_b_prod[k][2] - t_q64'(r_b_qe[k] * t_q64'(DIVN));

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                // fold this term into the running sum, start the next one
                r_b_pp[k]     <= mul_parts(w_term_in, t_q64'(w_y_in));
                r_b_sum[k][0] <= ADD ? (w_sum_in + w_term_in) : (w_sum_in - w_term_in);
                r_b_y[k][0]   <= w_y_in;

                r_b_prod[k][0] <= mul_round(r_b_pp[k]);
                r_b_rp[k]      <= mul_parts(r_b_prod[k][0], RECIP);
                r_b_prod[k][1] <= r_b_prod[k][0];
                r_b_qe[k]      <= mul_high(r_b_rp[k]);
                r_b_prod[k][2] <= r_b_prod[k][1];

                // reciprocal estimate is low by at most one
                r_b_term[k] <= r_b_qe[k] + t_q64'(w_rem >= t_q64'(DIVN));

                for (int s = 1; s < N_SUB; s++) begin
                    r_b_sum[k][s] <= r_b_sum[k][s-1];
                    r_b_y[k][s]   <= r_b_y[k][s-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sum <= r_b_sum[N_TERMS-1][N_SUB-1] + r_b_term[N_TERMS-1];
        end
    end

    for (genvar j = 0; j < N_SQ; j++) begin : g_sq
        t_q64 w_in;
        if (j == 0) begin : g_first
            assign w_in = r_sum;
        end else begin : g_next
            assign w_in = r_sq[j-1];
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_sq_pp[j] <= mul_parts(w_in, w_in);
                r_sq[j]    <= mul_round(r_sq_pp[j]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (r_zero[EXP_LAT-2]) begin
                r_e <= '0;
            end else if (r_sq[N_SQ-1] > Q_ONE) begin
                r_e <= Q_ONE;
            end else begin
                r_e <= r_sq[N_SQ-1];
            end
        end
    end

    assign o_e = r_e;

endmodule

// ----- design/tubular_vesselness_score.sv -----
// Tubular vesselness score from three Hessian eigenvalues, fully pipelined.
// Depends on tvs_pkg and tvs_exp.
//
// Channel   Dir   Handshake            Payload
// -------   ---   ------------------   -----------------------------------
// voxel     in    i_valid / o_stall    i_eigen_a, i_eigen_b, i_eigen_c
// score     out   o_valid / i_stall    o_score
// config    in    i_cfg_wr_en          i_cfg_wr_data (peak intensity)
//
// One voxel enters per cycle while o_stall is low.
// The pipeline holds the 57-step restoring dividers for the eigenvalue ratios,
// the 58-step dividers by the squared peak intensity, and the 103-stage exp pipeline.
// Reset clears the valid bits, including the output and skid flags, and loads a peak intensity of 255.
// All stages advance together; a result that meets a stalled output lands in a skid
// register, and o_stall rises on the next cycle so nothing is dropped or repeated.
module tubular_vesselness_score
    import tvs_pkg::*;
#(
    parameter int EIGEN_WIDTH     = EIGEN_WIDTH_DEF,
    parameter int SCORE_FRAC_BITS = SCORE_FRAC_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic signed [EIGEN_WIDTH-1:0]     i_eigen_a,
    input  logic signed [EIGEN_WIDTH-1:0]     i_eigen_b,
    input  logic signed [EIGEN_WIDTH-1:0]     i_eigen_c,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic [SCORE_FRAC_BITS-1:0]        o_score,
    input  logic                              i_cfg_wr_en,
    input  logic [15:0]                       i_cfg_wr_data
);

    localparam int W   = EIGEN_WIDTH;
    localparam int DW  = ((W > 32) ? W : 32) + 1;   // ratio divider remainder
    localparam int CW  = (W > 33) ? W : 33;         // magnitude vs 2*M compare
    localparam int TN  = QF + 2;                    // numerator bits of 2*R / M^2
    localparam int N_LANE = 4;
    localparam int N_TD   = 2;
    localparam int N_TS_DLY = QF - 1;
    localparam int TF  = 2 * QF + 10 + EXP_LAT;     // last product stage
    localparam int T_BIG = TF - 5;
    localparam int SH  = QF - SCORE_FRAC_BITS;

    // ratio lanes
    localparam int LN_P = 0;
    localparam int LN_U = 1;
    localparam int LN_V = 2;
    localparam int LN_Z = 3;
    // first product layer
    localparam int PR_RA = 0;
    localparam int PR_RB = 1;
    localparam int PR_UU = 2;
    localparam int PR_ZZ = 3;

    localparam logic [64:0] SMAX = 65'((65'd1 << SCORE_FRAC_BITS) - 65'd1);

    logic r_skid_v;
    logic en;
    assign en = !r_skid_v;

    // ---------------- configuration ----------------
    logic [15:0] r_max_int;
    logic [31:0] r_mm;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_int <= MAX_INT_RESET;
        end else if (i_cfg_wr_en) begin
            r_max_int <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mm <= 32'(r_max_int) * 32'(r_max_int);
    end

    // ---------------- stage A1: magnitudes ----------------
    logic         r_v1;
    logic [W-1:0] r_mag_a, r_mag_b, r_mag_c;
    logic         r_neg_a, r_neg_b, r_neg_c;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (en) begin
            r_v1 <= i_valid;
        end
    end

    // two's complement negate also gives the most negative value's magnitude exactly
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_neg_a <= i_eigen_a[W-1];
            r_neg_b <= i_eigen_b[W-1];
            r_neg_c <= i_eigen_c[W-1];
            r_mag_a <= i_eigen_a[W-1] ? ($unsigned(~i_eigen_a) + 1'b1) : $unsigned(i_eigen_a);
            r_mag_b <= i_eigen_b[W-1] ? ($unsigned(~i_eigen_b) + 1'b1) : $unsigned(i_eigen_b);
            r_mag_c <= i_eigen_c[W-1] ? ($unsigned(~i_eigen_c) + 1'b1) : $unsigned(i_eigen_c);
        end
    end

    // ---------------- stage A2: order by magnitude ----------------
    logic [W-1:0] n_a1, n_a2, n_a3;
    logic         n_neg2, n_neg3, n_big3;
    logic         lt_ab, lt_ba, lt_ac, lt_ca, lt_bc, lt_cb;
    logic         big_a, big_b, big_c;
    logic [CW-1:0] w_two_m;
    t_ctl         n_ctl0;

    logic [W-1:0] r_a1, r_a2, r_a3;
    t_ctl         r_ctl [TF+1];

    assign w_two_m = CW'({r_max_int, 17'd0});

    always_comb begin
        lt_ab = r_mag_a < r_mag_b;
        lt_ba = r_mag_b < r_mag_a;
        lt_ac = r_mag_a < r_mag_c;
        lt_ca = r_mag_c < r_mag_a;
        lt_bc = r_mag_b < r_mag_c;
        lt_cb = r_mag_c < r_mag_b;
        big_a = CW'(r_mag_a) >= w_two_m;
        big_b = CW'(r_mag_b) >= w_two_m;
        big_c = CW'(r_mag_c) >= w_two_m;

        if (!lt_ba && !lt_ca) begin
            n_a1 = r_mag_a;
            if (lt_bc) begin
                n_a2 = r_mag_b; n_neg2 = r_neg_b;
                n_a3 = r_mag_c; n_neg3 = r_neg_c; n_big3 = big_c;
            end else begin
                n_a2 = r_mag_c; n_neg2 = r_neg_c;
                n_a3 = r_mag_b; n_neg3 = r_neg_b; n_big3 = big_b;
            end
        end else if (!lt_ab && !lt_cb) begin
            n_a1 = r_mag_b;
            if (lt_ac) begin
                n_a2 = r_mag_a; n_neg2 = r_neg_a;
                n_a3 = r_mag_c; n_neg3 = r_neg_c; n_big3 = big_c;
            end else begin
                n_a2 = r_mag_c; n_neg2 = r_neg_c;
                n_a3 = r_mag_a; n_neg3 = r_neg_a; n_big3 = big_a;
            end
        end else begin
            n_a1 = r_mag_c;
            if (lt_ab) begin
                n_a2 = r_mag_a; n_neg2 = r_neg_a;
                n_a3 = r_mag_b; n_neg3 = r_neg_b; n_big3 = big_b;
            end else begin
                n_a2 = r_mag_b; n_neg2 = r_neg_b;
                n_a3 = r_mag_a; n_neg3 = r_neg_a; n_big3 = big_a;
            end
        end

        n_ctl0.valid = r_v1;
        n_ctl0.kill  = !(n_neg2 && n_neg3) || (r_max_int == 16'd0);
        n_ctl0.big   = n_big3;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a1 <= n_a1;
            r_a2 <= n_a2;
            r_a3 <= n_a3;
        end
    end

    // control line: valid, zero-score and large-S flags ride along with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i <= TF; i++) begin
                r_ctl[i] <= '0;
            end
        end else if (en) begin
            r_ctl[0] <= n_ctl0;
            for (int i = 1; i <= TF; i++) begin
                r_ctl[i] <= r_ctl[i-1];
            end
        end
    end

    // ---------------- B: ratio dividers, one quotient bit per stage ----------------
    // p = a1/a2, u = a1/a3, v = a2/a3, z = a3/(M << 16), each with QF fraction bits
    logic [DW-1:0] w_dv_n [N_LANE];
    logic [DW-1:0] w_dv_d [N_LANE];
    logic [DW-1:0] r_dv_r [N_LANE][QF+1];
    logic [DW-1:0] r_dv_d [N_LANE][QF+1];
    logic [QF:0]   r_dv_q [N_LANE][QF+1];

    always_comb begin
        w_dv_n[LN_P] = DW'(r_a1);
        w_dv_d[LN_P] = DW'(r_a2);
        w_dv_n[LN_U] = DW'(r_a1);
        w_dv_d[LN_U] = DW'(r_a3);
        w_dv_n[LN_V] = DW'(r_a2);
        w_dv_d[LN_V] = DW'(r_a3);
        w_dv_n[LN_Z] = DW'(r_a3);
        w_dv_d[LN_Z] = DW'({r_max_int, 16'd0});
    end

    for (genvar l = 0; l < N_LANE; l++) begin : g_lane
        always_ff @(posedge i_clk) begin
            if (en) begin
                // integer bit: the numerator never reaches twice the divisor when used
                if (w_dv_n[l] >= w_dv_d[l]) begin
                    r_dv_q[l][0] <= (QF+1)'(1);
                    r_dv_r[l][0] <= w_dv_n[l] - w_dv_d[l];
                end else begin
                    r_dv_q[l][0] <= '0;
                    r_dv_r[l][0] <= w_dv_n[l];
                end
                r_dv_d[l][0] <= w_dv_d[l];
            end
        end

        for (genvar s = 1; s <= QF; s++) begin : g_step
            logic [DW-1:0] w_r2;
            logic          w_ge;
            assign w_r2 = {r_dv_r[l][s-1][DW-2:0], 1'b0};
            assign w_ge = w_r2 >= r_dv_d[l][s-1];
            always_ff @(posedge i_clk) begin
                if (en) begin
                    r_dv_q[l][s] <= {r_dv_q[l][s-1][QF-1:0], w_ge};
                    r_dv_r[l][s] <= w_ge ? (w_r2 - r_dv_d[l][s-1]) : w_r2;
                    r_dv_d[l][s] <= r_dv_d[l][s-1];
                end
            end
        end
    end

    // ---------------- C: Ra^2, Rb^2, u^2, z^2 ----------------
    t_q64 w_c_a [N_LANE];
    t_q64 w_c_b [N_LANE];
    t_pp  r_c_pp  [N_LANE];
    t_q64 r_c_res [N_LANE];

    always_comb begin
        w_c_a[PR_RA] = t_q64'(r_dv_q[LN_P][QF]);
        w_c_b[PR_RA] = t_q64'(r_dv_q[LN_U][QF]);
        w_c_a[PR_RB] = t_q64'(r_dv_q[LN_V][QF]);
        w_c_b[PR_RB] = t_q64'(r_dv_q[LN_V][QF]);
        w_c_a[PR_UU] = t_q64'(r_dv_q[LN_U][QF]);
        w_c_b[PR_UU] = t_q64'(r_dv_q[LN_U][QF]);
        w_c_a[PR_ZZ] = t_q64'(r_dv_q[LN_Z][QF]);
        w_c_b[PR_ZZ] = t_q64'(r_dv_q[LN_Z][QF]);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < N_LANE; i++) begin
                r_c_pp[i]  <= mul_parts(w_c_a[i], w_c_b[i]);
                r_c_res[i] <= mul_round(r_c_pp[i]);
            end
        end
    end

    // ---------------- D: tA, tB = 2*R / M^2 by long division ----------------
    logic [TN-1:0] w_td_n [N_TD];
    logic [TN-1:0] r_td_n [N_TD][TN];
    logic [TN-1:0] r_td_q [N_TD][TN];
    logic [31:0]   r_td_r [N_TD][TN];

    assign w_td_n[0] = {r_c_res[PR_RA][TN-2:0], 1'b0};
    assign w_td_n[1] = {r_c_res[PR_RB][TN-2:0], 1'b0};

    for (genvar l = 0; l < N_TD; l++) begin : g_td
        for (genvar s = 0; s < TN; s++) begin : g_step
            logic [TN-1:0] w_n;
            logic [TN-1:0] w_q;
            logic [31:0]   w_r;
            logic [32:0]   w_rr;
            logic          w_ge;
            if (s == 0) begin : g_first
                assign w_n = w_td_n[l];
                assign w_q = '0;
                assign w_r = '0;
            end else begin : g_next
                assign w_n = r_td_n[l][s-1];
                assign w_q = r_td_q[l][s-1];
                assign w_r = r_td_r[l][s-1];
            end
            assign w_rr = {w_r, w_n[TN-1-s]};
            assign w_ge = w_rr >= {1'b0, r_mm};
            always_ff @(posedge i_clk) begin
                if (en) begin
                    r_td_n[l][s] <= w_n;
                    r_td_q[l][s] <= {w_q[TN-2:0], w_ge};
                    r_td_r[l][s] <= w_ge ? 32'(w_rr - {1'b0, r_mm}) : w_rr[31:0];
                end
            end
        end
    end

    // tS = 8 * z^2 * (1 + Rb^2 + u^2), then delay to meet tA and tB
    t_q64 r_sumn, r_zz_d, r_ts;
    t_pp  r_ts_pp;
    t_q64 r_ts_d [N_TS_DLY];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sumn    <= Q_ONE + r_c_res[PR_RB] + r_c_res[PR_UU];
            r_zz_d    <= r_c_res[PR_ZZ];
            r_ts_pp   <= mul_parts(r_zz_d, r_sumn);
            r_ts      <= mul_round(r_ts_pp) << 3;
            r_ts_d[0] <= r_ts;
            for (int i = 1; i < N_TS_DLY; i++) begin
                r_ts_d[i] <= r_ts_d[i-1];
            end
        end
    end

    // ---------------- E: the three exponentials ----------------
    t_q64 w_e_a, w_e_b, w_e_s;

    tvs_exp u_exp_a (
        .i_clk (i_clk),
        .i_en  (en),
        .i_t   (t_q64'(r_td_q[0][TN-1])),
        .o_e   (w_e_a)
    );

    tvs_exp u_exp_b (
        .i_clk (i_clk),
        .i_en  (en),
        .i_t   (t_q64'(r_td_q[1][TN-1])),
        .o_e   (w_e_b)
    );

    tvs_exp u_exp_s (
        .i_clk (i_clk),
        .i_en  (en),
        .i_t   (r_ts_d[N_TS_DLY-1]),
        .o_e   (w_e_s)
    );

    // ---------------- F: product of the three factors ----------------
    t_q64 r_f1, r_f2, r_f3, r_f3_d1, r_f3_d2, r_p1, r_prod;
    t_pp  r_p1_pp, r_p2_pp;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_f1    <= w_e_a;
            r_f2    <= Q_ONE - w_e_b;
            // a large |l3| drives the structure term to one
            r_f3    <= r_ctl[T_BIG].big ? Q_ONE : (Q_ONE - w_e_s);
            r_p1_pp <= mul_parts(r_f1, r_f2);
            r_f3_d1 <= r_f3;
            r_p1    <= mul_round(r_p1_pp);
            r_f3_d2 <= r_f3_d1;
            r_p2_pp <= mul_parts(r_p1, r_f3_d2);
            r_prod  <= mul_round(r_p2_pp);
        end
    end

    // round to the score format, saturate, zero for non-tubular or zero intensity
    logic [64:0]                n_round;
    logic [64:0]                n_wide;
    logic [SCORE_FRAC_BITS-1:0] n_score;

    always_comb begin
        n_round = {1'b0, r_prod} + (65'd1 << (SH - 1));
        n_wide  = n_round >> SH;
        if (r_ctl[TF].kill) begin
            n_score = '0;
        end else if (n_wide > SMAX) begin
            n_score = SMAX[SCORE_FRAC_BITS-1:0];
        end else begin
            n_score = n_wide[SCORE_FRAC_BITS-1:0];
        end
    end

    // ---------------- output register and skid ----------------
    logic                       r_o_valid;
    logic [SCORE_FRAC_BITS-1:0] r_o_score;
    logic [SCORE_FRAC_BITS-1:0] r_skid;
    logic                       take;

    assign take = r_o_valid && !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
            r_skid_v  <= 1'b0;
        end else if (r_skid_v) begin
            // pipeline frozen; drain the skid once the output moves
            if (take) begin
                r_o_valid <= 1'b1;
                r_skid_v  <= 1'b0;
            end
        end else if (r_ctl[TF].valid) begin
            if (!r_o_valid || take) begin
                r_o_valid <= 1'b1;
            end else begin
                r_skid_v <= 1'b1;
            end
        end else if (take) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_v) begin
            if (take) begin
                r_o_score <= r_skid;
            end
        end else if (r_ctl[TF].valid) begin
            if (!r_o_valid || take) begin
                r_o_score <= n_score;
            end else begin
                r_skid <= n_score;
            end
        end
    end

    assign o_valid = r_o_valid;
    assign o_score = r_o_score;
    assign o_stall = r_skid_v;

endmodule

// ----- test/tubular_vesselness_score_tb.sv -----
// Self-checking testbench for tubular_vesselness_score: directed table, then random voxels.
// Depends on tvs_pkg and the tubular_vesselness_score RTL; needs nothing else.
// A local bit-exact score predictor supplies every expectation not typed in the table.
module tubular_vesselness_score_tb;
    import tvs_pkg::*;

    localparam int EW            = 32;
    localparam int SW            = 16;
    localparam int RANDOM_VOXELS = 1700;
    localparam int IDLE_LIMIT    = 20000;   // cycles with no transfer on either side
    localparam int LONG_HOLD     = 700;     // well past the pipeline depth
    localparam int FQ            = 56;

    typedef logic signed [EW-1:0] t_eig;
    typedef logic [SW-1:0]        t_score;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    t_eig        i_eigen_a = '0;
    t_eig        i_eigen_b = '0;
    t_eig        i_eigen_c = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    t_score      o_score;
    logic        i_cfg_wr_en = 1'b0;
    logic [15:0] i_cfg_wr_data = '0;

    tubular_vesselness_score #(.EIGEN_WIDTH(EW), .SCORE_FRAC_BITS(SW)) DUT (.*);

    always #5 i_clk = ~i_clk;

    // ---------------------------------------------------------------
    // Score predictor, Q.56 internal fixed point
    // ---------------------------------------------------------------
    logic [15:0] cur_max_int;     // predictor copy of the peak intensity
    t_score      score_fifo[$];   // expected scores, oldest first
    int          fail_count = 0;
    int          idle_cycles = 0;

    // (a*b) >> 56, rounded half up
    function automatic t_q64 fx_mul(input t_q64 a, input t_q64 b);
        logic [127:0] w;
        w = {64'd0, a} * {64'd0, b} + (128'd1 << (FQ - 1));
        return w[FQ+63:FQ];
    endfunction

    // floor(n * 2^k / d)
    function automatic t_q64 fx_div(input t_q64 n, input t_q64 d, input int k);
        logic [127:0] w;
        if (d == 0) return '0;
        w = ({64'd0, n} << k) / {64'd0, d};
        return w[63:0];
    endfunction

    // exp(-t): Taylor series on t/1024, then square ten times
    function automatic t_q64 decay(input t_q64 t);
        t_q64 y, term, acc;
        if (t >= (t_q64'(128) << FQ)) return '0;
        y = t >> 10;
        term = t_q64'(1) << FQ;
        acc = term;
        for (int n = 1; n <= 16; n++) begin
            term = fx_mul(term, y) / t_q64'(n);
            if (n % 2 == 1) acc = acc - term;
            else acc = acc + term;
        end
        for (int n = 0; n < 10; n++) acc = fx_mul(acc, acc);
        return (acc > (t_q64'(1) << FQ)) ? (t_q64'(1) << FQ) : acc;
    endfunction

    function automatic t_score vesselness(input t_eig ea, input t_eig eb, input t_eig ec,
                                          input logic [15:0] mi);
        t_eig  ev[3];
        logic  neg[3];
        t_q64  mag[3];
        int    k1, k2, k3;
        t_q64  one, a1, a2, a3, m, p, u, v, ra, rb, mm, ta, tb, f1, f2, f3, z, sn, ts, prod, sc;
        one = t_q64'(1) << FQ;
        ev[0] = ea; ev[1] = eb; ev[2] = ec;
        for (int i = 0; i < 3; i++) begin
            neg[i] = ev[i][EW-1];
            mag[i] = neg[i] ? (t_q64'(1) << EW) - t_q64'(unsigned'(ev[i]))
                            : t_q64'(unsigned'(ev[i]));
        end
        // order by magnitude; on a tie the later of the remaining two becomes l2
        if (mag[0] <= mag[1] && mag[0] <= mag[2]) begin
            k1 = 0;
            if (mag[1] < mag[2]) begin k2 = 1; k3 = 2; end else begin k2 = 2; k3 = 1; end
        end else if (mag[1] <= mag[0] && mag[1] <= mag[2]) begin
            k1 = 1;
            if (mag[0] < mag[2]) begin k2 = 0; k3 = 2; end else begin k2 = 2; k3 = 0; end
        end else begin
            k1 = 2;
            if (mag[0] < mag[1]) begin k2 = 0; k3 = 1; end else begin k2 = 1; k3 = 0; end
        end
        m = t_q64'(mi);
        if (!(neg[k2] && neg[k3]) || m == 0) return '0;
        a1 = mag[k1]; a2 = mag[k2]; a3 = mag[k3];
        p  = fx_div(a1, a2, FQ);
        u  = fx_div(a1, a3, FQ);
        v  = fx_div(a2, a3, FQ);
        ra = fx_mul(p, u);
        rb = fx_mul(v, v);
        mm = m * m;
        ta = (ra << 1) / mm;
        tb = (rb << 1) / mm;
        f1 = decay(ta);
        f2 = one - decay(tb);
        // structure term saturates to 1 once |l3| reaches 2*M
        if (a3 >= (m << 17)) begin
            f3 = one;
        end else begin
            z  = fx_div(a3, m << 16, FQ);
            sn = one + rb + fx_mul(u, u);
            ts = fx_mul(fx_mul(z, z), sn) << 3;
            f3 = one - decay(ts);
        end
        prod = fx_mul(fx_mul(f1, f2), f3);
        sc = (prod + (t_q64'(1) << (FQ - 1 - SW))) >> (FQ - SW);
        if (sc > t_q64'((1 << SW) - 1)) sc = t_q64'((1 << SW) - 1);
        return t_score'(sc);
    endfunction

    // ---------------------------------------------------------------
    // Voxel sender
    // ---------------------------------------------------------------
    // Hold valid and payload until the block takes the transfer; valid stays
    // high afterward so back-to-back calls form a burst.
    task automatic send_voxel(input t_eig ea, input t_eig eb, input t_eig ec,
                              input logic typed, input t_score typed_score);
        i_valid   <= 1'b1;
        i_eigen_a <= ea;
        i_eigen_b <= eb;
        i_eigen_c <= ec;
        do @(posedge i_clk); while (o_stall);
        score_fifo.push_back(typed ? typed_score : vesselness(ea, eb, ec, cur_max_int));
    endtask

    task automatic pause_sender(input int cycles);
        i_valid <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    // Drop valid and wait for every outstanding score.
    task automatic drain;
        i_valid <= 1'b0;
        while (score_fifo.size() != 0) @(posedge i_clk);
    endtask

    // Write the peak intensity; only called with the pipeline empty.
    task automatic write_max_int(input logic [15:0] value);
        drain();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        cur_max_int = value;
    endtask

    // Tube-like voxel: one big negative, one mostly negative, a weaker third, any order.
    task automatic send_tube(input logic [15:0] mi);
        t_q64 big_mag, mid_mag, low_mag, cap;
        t_eig e[3];
        int   r;
        cap     = (t_q64'(1) << 31);
        big_mag = (t_q64'($urandom_range(1, 4 * (int'(mi) + 1))) << 16) | $urandom_range(0, 65535);
        if (big_mag > cap) big_mag = cap - $urandom_range(0, 1 << 20);
        mid_mag = big_mag * $urandom_range(1, 1000) / 1000;
        low_mag = mid_mag * $urandom_range(0, 1000) / 1000;
        e[0] = t_eig'(-$signed({1'b0, big_mag[31:0]}));
        e[1] = ($urandom_range(0, 15) == 0) ? t_eig'(mid_mag) : t_eig'(-$signed({1'b0, mid_mag[31:0]}));
        e[2] = $urandom_range(0, 1) ? t_eig'(low_mag) : t_eig'(-$signed({1'b0, low_mag[31:0]}));
        r = $urandom_range(0, 5);
        case (r)
            0: send_voxel(e[0], e[1], e[2], 1'b0, '0);
            1: send_voxel(e[0], e[2], e[1], 1'b0, '0);
            2: send_voxel(e[1], e[0], e[2], 1'b0, '0);
            3: send_voxel(e[1], e[2], e[0], 1'b0, '0);
            4: send_voxel(e[2], e[0], e[1], 1'b0, '0);
            default: send_voxel(e[2], e[1], e[0], 1'b0, '0);
        endcase
    endtask

    // ---------------------------------------------------------------
    // Score receiver and checker
    // ---------------------------------------------------------------
    logic hold_req = 1'b0;   // main sequence asks for one long hold-off
    int   hold_left = 0;
    int   stall_pct = 0;
    int   seg_left = 0;

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (score_fifo.size() == 0) begin
                $display("%0t: unexpected score transfer, actual %h", $time, o_score);
                fail_count++;
            end else begin
                if (o_score !== score_fifo[0]) begin
                    $display("%0t: score mismatch, expected %h actual %h",
                             $time, score_fifo[0], o_score);
                    fail_count++;
                end
                void'(score_fifo.pop_front());
            end
        end
        // stall pattern: segments of random density, some with no stall at all
        if (seg_left == 0) begin
            seg_left  = $urandom_range(20, 300);
            stall_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 80);
        end else begin
            seg_left--;
        end
        if (hold_req && hold_left == 0) begin
            hold_left = LONG_HOLD;
            hold_req  = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    // watchdog: clear on any transfer or reset, otherwise count toward the limit
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || !i_rst_n) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ---------------------------------------------------------------
    // Directed table
    // ---------------------------------------------------------------
    typedef struct {
        logic [15:0] max_int;
        t_eig        ea, eb, ec;
        logic        typed;   // score below is known outright
        t_score      score;
    } t_row;

    localparam t_eig MOST_NEG = t_eig'(32'h8000_0000);
    localparam t_eig MOST_POS = t_eig'(32'h7fff_ffff);

    t_row rows[$] = '{
        // after reset, peak intensity = 255
        '{16'd255, 32'sd0, 32'sd0, 32'sd0, 1'b1, 16'd0},
        '{16'd255, MOST_POS, MOST_POS, MOST_POS, 1'b1, 16'd0},
        '{16'd255, 32'sd0, 32'sd5 <<< 16, -(32'sd20 <<< 16), 1'b1, 16'd0},
        '{16'd255, MOST_NEG, MOST_NEG, MOST_NEG, 1'b0, 16'd0},
        '{16'd255, -32'sd1, -32'sd1, -32'sd1, 1'b0, 16'd0},
        '{16'd255, 32'sd1 <<< 16, -(32'sd10 <<< 16), -(32'sd20 <<< 16), 1'b0, 16'd0},
        '{16'd255, -(32'sd3 <<< 16), -(32'sd3 <<< 16), -(32'sd3 <<< 16), 1'b0, 16'd0},
        '{16'd255, -(32'sd400 <<< 16), 32'sd0, -(32'sd400 <<< 16), 1'b0, 16'd0},
        '{16'd255, -(32'sd600 <<< 16), -(32'sd700 <<< 16), 32'sd1 <<< 16, 1'b0, 16'd0},
        '{16'd255, -(32'sd200 <<< 16), 32'sd2 <<< 16, -(32'sd180 <<< 16), 1'b0, 16'd0},
        // zero intensity always scores zero
        '{16'd0, -(32'sd5 <<< 16), -(32'sd6 <<< 16), -(32'sd1 <<< 16), 1'b1, 16'd0},
        '{16'd0, MOST_NEG, MOST_NEG, MOST_NEG, 1'b1, 16'd0},
        // smallest nonzero intensity
        '{16'd1, 32'sd0, -(32'sd1 <<< 16), -(32'sd1 <<< 16), 1'b0, 16'd0},
        '{16'd1, -32'sd100, -(32'sd1 <<< 15), -(32'sd3 <<< 16), 1'b0, 16'd0},
        '{16'd1, MOST_POS, MOST_NEG, MOST_NEG, 1'b0, 16'd0},
        // largest intensity
        '{16'hffff, MOST_NEG, MOST_NEG, -32'sd1, 1'b0, 16'd0},
        '{16'hffff, 32'sd0, MOST_NEG, -(32'sd30000 <<< 16), 1'b0, 16'd0},
        '{16'hffff, -(32'sd1000 <<< 16), -(32'sd20000 <<< 16), -(32'sd30000 <<< 16), 1'b0, 16'd0},
        '{16'hffff, MOST_POS, MOST_POS, MOST_NEG, 1'b1, 16'd0}
    };

    localparam logic [15:0] PHASE_MI [6] = '{16'd255, 16'd1, 16'hffff, 16'd16, 16'd0, 16'd4000};

    initial begin
        int sent;
        cur_max_int = MAX_INT_RESET;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[i]) begin
            if (rows[i].max_int != cur_max_int) write_max_int(rows[i].max_int);
            send_voxel(rows[i].ea, rows[i].eb, rows[i].ec, rows[i].typed, rows[i].score);
            if ($urandom_range(0, 2) == 0) pause_sender($urandom_range(1, 4));
        end

        // random phases, each under its own intensity; a random one to end with
        sent = 0;
        for (int ph = 0; ph < 7; ph++) begin
            write_max_int(ph < 6 ? PHASE_MI[ph] : 16'($urandom_range(0, 65535)));
            if (ph == 2) hold_req = 1'b1;   // back up the whole pipeline once
            for (int n = 0; n < RANDOM_VOXELS / 7; n++) begin
                if ($urandom_range(0, 4) == 0)
                    send_voxel(t_eig'($urandom()), t_eig'($urandom()), t_eig'($urandom()),
                               1'b0, '0);
                else
                    send_tube(cur_max_int);
                sent++;
                // burst ends at random, then a random gap
                if ($urandom_range(0, 11) == 0) pause_sender($urandom_range(1, 30));
            end
        end

        drain();
        repeat (300) @(posedge i_clk);
        if (fail_count == 0 && score_fifo.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ----- filelist.f -----
design/tvs_pkg.sv
design/tvs_exp.sv
design/tubular_vesselness_score.sv
test/tubular_vesselness_score_tb.sv
